FILE: rtl/core/alm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the audio level meter bargraph core.
// No dependencies.
package alm_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SUM_W     = 17;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned Y_W       = 48;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned LED_W     = 10;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam int unsigned NUM_SEGMENTS    = 10;
  localparam int unsigned PEAK_DECAY_LOG2 = 5;

  localparam logic [COEF_W-1:0]  B0_RST = 32'sd1073201088;
  localparam logic [COEF_W-1:0]  B1_RST = -32'sd2146402175;
  localparam logic [COEF_W-1:0]  A1_RST = -32'sd2146401895;
  localparam logic [COEF_W-1:0]  A2_RST = 32'sd1072660619;
  localparam logic [LEVEL_W-1:0] LOCAL_DECAY_RST = 16'd64881;
  localparam logic [LEVEL_W-1:0] PEAK_DECAY_RST  = 16'd65470;
  localparam logic [CHAN_W-1:0]  CHAN_RST        = 2'd2;
  localparam logic [CHAN_W-1:0]  CHAN_ONE        = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0          = 3'd0,
    CFG_B1          = 3'd1,
    CFG_A1          = 3'd2,
    CFG_A2          = 3'd3,
    CFG_LOCAL_DECAY = 3'd4,
    CFG_PEAK_DECAY  = 3'd5,
    CFG_CHAN_COUNT  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
  } alm_coef_t;

  // floor(32768 * 10^(-d/20)), 1 dB steps
  localparam int unsigned SEG_THR_N = 17;
  localparam logic [LEVEL_W-1:0] SEG_THR [SEG_THR_N] = '{
    16'd32768, 16'd29204, 16'd26028, 16'd23197, 16'd20675, 16'd18426,
    16'd16422, 16'd14636, 16'd13045, 16'd11626, 16'd10362, 16'd9235,
    16'd8230,  16'd7335,  16'd6538,  16'd5827,  16'd5193
  };

endpackage

FILE: rtl/core/alm_biquad.sv
`timescale 1ns / 1ps
// DC-blocking biquad on the channel sum (left channel alone in mono), Q2.30
// coefficients, saturating 48-bit output history. Depends on alm_pkg.
module alm_biquad (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      two_i,
  input  alm_pkg::alm_coef_t        coef_i,
  input  logic [alm_pkg::SAMPLE_W-1:0] left_i,
  input  logic [alm_pkg::SAMPLE_W-1:0] right_i,
  output logic [alm_pkg::Y_W-1:0]   y_o
);
  import alm_pkg::*;

  localparam int unsigned ACC_W = 84;

  logic signed [SUM_W-1:0] x0_d;
  logic signed [SUM_W-1:0] x1_q, x2_q;
  logic signed [Y_W-1:0]   y1_q, y2_q;
  logic signed [Y_W-1:0]   y_d;

  logic signed [48:0] p_b0x0, p_b1x1, p_b0x2;
  logic signed [50:0] ff;
  logic signed [23:0] y1_hi, y2_hi;
  logic signed [24:0] y1_lo, y2_lo;
  logic signed [55:0] p_a1h, p_a2h;
  logic signed [56:0] p_a1l, p_a2l;
  logic [ACC_W-1:0]   ff_sh, fb1, fb2, acc;

  always_comb begin
    if (two_i) begin
      x0_d = $signed({left_i[SAMPLE_W-1], left_i}) + $signed({right_i[SAMPLE_W-1], right_i});
    end else begin
      x0_d = $signed({left_i[SAMPLE_W-1], left_i});
    end
  end

  assign p_b0x0 = $signed(coef_i.b0) * x0_d;
  assign p_b1x1 = $signed(coef_i.b1) * x1_q;
  assign p_b0x2 = $signed(coef_i.b0) * x2_q;
  assign ff = {{2{p_b0x0[48]}}, p_b0x0} + {{2{p_b1x1[48]}}, p_b1x1}
            + {{2{p_b0x2[48]}}, p_b0x2};

  // feedback split into signed upper and unsigned lower 24-bit halves
  assign y1_hi = y1_q[47:24];
  assign y2_hi = y2_q[47:24];
  assign y1_lo = $signed({1'b0, y1_q[23:0]});
  assign y2_lo = $signed({1'b0, y2_q[23:0]});

  assign p_a1h = $signed(coef_i.a1) * y1_hi;
  assign p_a1l = $signed(coef_i.a1) * y1_lo;
  assign p_a2h = $signed(coef_i.a2) * y2_hi;
  assign p_a2l = $signed(coef_i.a2) * y2_lo;

  assign ff_sh = {{21{ff[50]}}, ff, 12'b0};
  assign fb1 = {{4{p_a1h[55]}}, p_a1h, 24'b0} + {{27{p_a1l[56]}}, p_a1l};
  assign fb2 = {{4{p_a2h[55]}}, p_a2h, 24'b0} + {{27{p_a2l[56]}}, p_a2l};
  assign acc = ff_sh - fb1 - fb2;

  // floor by 2^30, then saturate to 48 bits
  always_comb begin
    if ((acc[83:77] == 7'h00) || (acc[83:77] == 7'h7F)) begin
      y_d = $signed(acc[77:30]);
    end else if (acc[83]) begin
      y_d = $signed({1'b1, {(Y_W-1){1'b0}}});
    end else begin
      y_d = $signed({1'b0, {(Y_W-1){1'b1}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (en_i) begin
      x1_q <= x0_d;
      x2_q <= x1_q;
      y1_q <= y_d;
      y2_q <= y1_q;
    end
  end

  assign y_o = y1_q;

endmodule

FILE: rtl/core/alm_level.sv
`timescale 1ns / 1ps
// Fast local level and slow peak level with periodic decay.
// Depends on alm_pkg.
module alm_level #(
  parameter int unsigned PeakDecayLog2 = alm_pkg::PEAK_DECAY_LOG2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        two_i,
  input  logic [alm_pkg::Y_W-1:0]     y_i,
  input  logic [alm_pkg::LEVEL_W-1:0] local_decay_i,
  input  logic [alm_pkg::LEVEL_W-1:0] peak_decay_i,
  output logic [alm_pkg::LEVEL_W-1:0] fast_o,
  output logic [alm_pkg::LEVEL_W-1:0] peak_o
);
  import alm_pkg::*;

  localparam int unsigned CntW = (PeakDecayLog2 > 0) ? PeakDecayLog2 : 1;

  logic [Y_W-1:0]       mag;
  logic [Y_W-13:0]      lvl_wide;
  logic [LEVEL_W-1:0]   lvl;
  logic [2*LEVEL_W-1:0] fast_prod, peak_prod;
  logic [LEVEL_W-1:0]   fast_q, fast_d, peak_q, peak_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  assign mag      = y_i[Y_W-1] ? (~y_i + 1'b1) : y_i;
  assign lvl_wide = two_i ? {1'b0, mag[Y_W-1:13]} : mag[Y_W-1:12];
  assign lvl      = (|lvl_wide[Y_W-13:LEVEL_W]) ? {LEVEL_W{1'b1}} : lvl_wide[LEVEL_W-1:0];

  assign fast_prod = fast_q * local_decay_i;
  assign peak_prod = peak_q * peak_decay_i;

  always_comb begin
    fast_d = (lvl > fast_q) ? lvl : fast_prod[2*LEVEL_W-1:LEVEL_W];
    if (lvl > peak_q) begin
      peak_d = lvl;
    end else if (cnt_q == '0) begin
      peak_d = peak_prod[2*LEVEL_W-1:LEVEL_W];
    end else begin
      peak_d = peak_q;
    end
    cnt_d = (PeakDecayLog2 == 0) ? '0 : cnt_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      peak_q <= '0;
      cnt_q  <= '0;
    end else if (en_i) begin
      fast_q <= fast_d;
      peak_q <= peak_d;
      cnt_q  <= cnt_d;
    end
  end

  assign fast_o = fast_q;
  assign peak_o = peak_q;

endmodule

FILE: rtl/core/alm_bargraph.sv
`timescale 1ns / 1ps
// Bargraph decode against 1 dB thresholds and the result register.
// Depends on alm_pkg.
module alm_bargraph (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [alm_pkg::LEVEL_W-1:0] fast_i,
  input  logic [alm_pkg::LEVEL_W-1:0] peak_i,
  output logic [alm_pkg::LED_W-1:0]   led_o,
  output logic [alm_pkg::LEVEL_W-1:0] fast_o,
  output logic [alm_pkg::LEVEL_W-1:0] peak_o
);
  import alm_pkg::*;

  logic [LED_W-1:0]   led_d, led_q;
  logic [LEVEL_W-1:0] fast_q, peak_q;

  for (genvar g = 0; g < LED_W; g++) begin : g_seg
    if (g < NUM_SEGMENTS) begin : g_on
      localparam int unsigned LoIdx = NUM_SEGMENTS - g;
      localparam int unsigned HiIdx = NUM_SEGMENTS - g - 1;
      assign led_d[g] = (fast_i > SEG_THR[LoIdx])
                      || ((peak_i > SEG_THR[LoIdx]) && (peak_i <= SEG_THR[HiIdx]));
    end else begin : g_off
      assign led_d[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      led_q  <= led_d;
      fast_q <= fast_i;
      peak_q <= peak_i;
    end
  end

  assign led_o  = led_q;
  assign fast_o = fast_q;
  assign peak_o = peak_q;

endmodule

FILE: rtl/core/audio_level_meter_bargraph_core.sv
`timescale 1ns / 1ps
// Audio level meter with peak hold and 10-segment bargraph.
// Registered stages from input beat to result beat: input, filter, level, result.
// Throughput: one beat per cycle unless stalled; the biquad multiply-add is the loop.
// A result-side stall holds the whole pipeline; an empty input register still fills.
// Reset clears histories, levels and frame counter and loads default coefficients.
module audio_level_meter_bargraph_core #(
  parameter int unsigned PeakDecayLog2 = alm_pkg::PEAK_DECAY_LOG2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [alm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [alm_pkg::CFG_DAT_W-1:0]    cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] left_sample, [31:16] right_sample
  input  logic [alm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] led_pattern, [25:10] local_level, [41:26] peak_level, [47:42] zero
  output logic [alm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import alm_pkg::*;

  alm_coef_t          coef_q;
  logic [LEVEL_W-1:0] local_decay_q, peak_decay_q;
  logic [CHAN_W-1:0]  chan_q;
  logic               two;

  logic                s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [SAMPLE_W-1:0] left_q, right_q;
  logic                adv, s1_load;

  logic [Y_W-1:0]     y;
  logic [LEVEL_W-1:0] fast, peak;
  logic [LED_W-1:0]   led_out;
  logic [LEVEL_W-1:0] fast_out, peak_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0     <= B0_RST;
      coef_q.b1     <= B1_RST;
      coef_q.a1     <= A1_RST;
      coef_q.a2     <= A2_RST;
      local_decay_q <= LOCAL_DECAY_RST;
      peak_decay_q  <= PEAK_DECAY_RST;
      chan_q        <= CHAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_B0:          coef_q.b0     <= cfg_wdata_i;
        CFG_B1:          coef_q.b1     <= cfg_wdata_i;
        CFG_A1:          coef_q.a1     <= cfg_wdata_i;
        CFG_A2:          coef_q.a2     <= cfg_wdata_i;
        CFG_LOCAL_DECAY: local_decay_q <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_PEAK_DECAY:  peak_decay_q  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_CHAN_COUNT:  chan_q        <= cfg_wdata_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign two = (chan_q != CHAN_ONE);

  assign adv     = !s4_valid_q || m_axis_tready;
  assign s1_load = adv || !s1_valid_q;
  assign s_axis_tready = s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && s_axis_tvalid) begin
      left_q  <= s_axis_tdata[SAMPLE_W-1:0];
      right_q <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  alm_biquad u_biquad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv && s1_valid_q),
    .two_i   (two),
    .coef_i  (coef_q),
    .left_i  (left_q),
    .right_i (right_q),
    .y_o     (y)
  );

  alm_level #(
    .PeakDecayLog2 (PeakDecayLog2)
  ) u_level (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv && s2_valid_q),
    .two_i         (two),
    .y_i           (y),
    .local_decay_i (local_decay_q),
    .peak_decay_i  (peak_decay_q),
    .fast_o        (fast),
    .peak_o        (peak)
  );

  alm_bargraph u_bargraph (
    .clk_i  (clk_i),
    .en_i   (adv && s3_valid_q),
    .fast_i (fast),
    .peak_i (peak),
    .led_o  (led_out),
    .fast_o (fast_out),
    .peak_o (peak_out)
  );

  assign m_axis_tvalid = s4_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - LED_W - 2*LEVEL_W){1'b0}}, peak_out, fast_out, led_out};

endmodule

FILE: dv/tb_audio_level_meter_bargraph_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for audio_level_meter_bargraph_core: frames in, bargraph readings out.
// Holds its own model of the filter and meters and compares every result beat field by field.
// Depends on alm_pkg and the core RTL only.
module tb_audio_level_meter_bargraph_core;
  import alm_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // floor(32768 * 10^(-d/20)), d = 0..16
  localparam int unsigned BAND_EDGE [17] = '{
    32768, 29204, 26028, 23197, 20675, 18426, 16422, 14636, 13045,
    11626, 10362, 9235, 8230, 7335, 6538, 5827, 5193
  };

  localparam logic [31:0] OPENING_FRAMES [21] = '{
    32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_8000, 32'h8000_7FFF,
    32'h7FFF_8000, 32'hFFFF_0001, 32'h0000_FFFF, 32'h4000_4000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_0000
  };

  typedef struct packed {
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] fast;
    logic [LED_W-1:0]   leds;
  } meter_reading_t;

  class level_meter_scoreboard;
    logic signed [COEF_W-1:0] b0, b1, a1, a2;
    logic [LEVEL_W-1:0]       local_decay, peak_decay;
    logic [CHAN_W-1:0]        chan;
    logic signed [SUM_W-1:0]  x_d1, x_d2;
    logic signed [Y_W-1:0]    y_d1, y_d2;
    logic [LEVEL_W-1:0]       fast, peak;
    logic [PEAK_DECAY_LOG2-1:0] frame_cnt;
    meter_reading_t           readings_due[$];
    int                       mismatches;

    function new();
      b0 = B0_RST;
      b1 = B1_RST;
      a1 = A1_RST;
      a2 = A2_RST;
      local_decay = LOCAL_DECAY_RST;
      peak_decay = PEAK_DECAY_RST;
      chan = CHAN_RST;
      x_d1 = '0;
      x_d2 = '0;
      y_d1 = '0;
      y_d2 = '0;
      fast = '0;
      peak = '0;
      frame_cnt = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        CFG_B0:          b0 = value;
        CFG_B1:          b1 = value;
        CFG_A1:          a1 = value;
        CFG_A2:          a2 = value;
        CFG_LOCAL_DECAY: local_decay = value[LEVEL_W-1:0];
        CFG_PEAK_DECAY:  peak_decay = value[LEVEL_W-1:0];
        CFG_CHAN_COUNT:  chan = value[CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function meter_reading_t step_meter(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right);
      logic                     two;
      logic signed [SUM_W-1:0]  x;
      logic signed [127:0]      wb0, wb1, wa1, wa2, wx, wx1, wx2, wy1, wy2, acc, q;
      logic signed [Y_W-1:0]    y;
      logic [Y_W-1:0]           mag, lvl_w;
      logic [LEVEL_W-1:0]       lvl;
      logic [31:0]              prod;
      meter_reading_t           r;
      two = (chan != CHAN_ONE);
      x = {left[SAMPLE_W-1], left} + (two ? {right[SAMPLE_W-1], right} : 17'd0);
      wb0 = 128'(b0);
      wb1 = 128'(b1);
      wa1 = 128'(a1);
      wa2 = 128'(a2);
      wx = 128'(x);
      wx1 = 128'(x_d1);
      wx2 = 128'(x_d2);
      wy1 = 128'(y_d1);
      wy2 = 128'(y_d2);
      acc = ((wb0 * wx + wb1 * wx1 + wb0 * wx2) <<< 12) - wa1 * wy1 - wa2 * wy2;
      q = acc >>> 30;
      if (q > ((128'sd1 <<< 47) - 128'sd1))
        y = {1'b0, {(Y_W-1){1'b1}}};
      else if (q < -(128'sd1 <<< 47))
        y = {1'b1, {(Y_W-1){1'b0}}};
      else
        y = q[Y_W-1:0];
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = y;

      mag = y[Y_W-1] ? -y : y;
      lvl_w = mag >> (two ? 13 : 12);
      lvl = (lvl_w > 48'd65535) ? 16'hFFFF : lvl_w[LEVEL_W-1:0];

      if (lvl > fast) begin
        fast = lvl;
      end else begin
        prod = 32'(fast) * 32'(local_decay);
        fast = prod[31:16];
      end
      if (lvl > peak) begin
        peak = lvl;
      end else if (frame_cnt == 0) begin
        prod = 32'(peak) * 32'(peak_decay);
        peak = prod[31:16];
      end
      frame_cnt = frame_cnt + 1'b1;

      r.leds = '0;
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
        if (fast > BAND_EDGE[NUM_SEGMENTS - i] ||
            (peak > BAND_EDGE[NUM_SEGMENTS - i] && peak <= BAND_EDGE[NUM_SEGMENTS - i - 1]))
          r.leds[i] = 1'b1;
      end
      r.fast = fast;
      r.peak = peak;
      return r;
    endfunction

    function void note_frame(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right);
      readings_due.push_back(step_meter(left, right));
    endfunction

    function void compare_field(string name, logic [LEVEL_W-1:0] want, logic [LEVEL_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_reading(logic [OUT_TDATA_W-1:0] beat);
      meter_reading_t want;
      if (readings_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none actual %h", $time, beat);
        return;
      end
      want = readings_due.pop_front();
      compare_field("led_pattern", 16'(want.leds), 16'(beat[9:0]));
      compare_field("local_level", want.fast, beat[25:10]);
      compare_field("peak_level", want.peak, beat[41:26]);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DAT_W-1:0]   cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  level_meter_scoreboard  meter_sb;
  bit                     src_idling;
  bit                     sink_idling;
  bit                     hold_off_req;
  int unsigned            cycle_count;

  audio_level_meter_bargraph_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      meter_sb.note_frame(s_axis_tdata[15:0], s_axis_tdata[31:16]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      meter_sb.check_reading(m_axis_tdata);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned held;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk_i);
          held++;
        end
        hold_off_req = 1'b0;
      end else if (sink_idling && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic send_frame(logic [IN_TDATA_W-1:0] frame);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= frame;
    do @(posedge clk_i); while (!s_axis_tready);
    if (src_idling && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic run_frames(int count);
    int          run_left;
    int unsigned shift;
    logic [15:0] left, right;
    run_left = 0;
    shift = 0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = int'($urandom_range(1, 40));
        shift = $urandom_range(0, 15);
      end
      run_left--;
      left = 16'($urandom);
      right = 16'($urandom);
      case ($urandom_range(0, 15))
        0: left = 16'h8000;
        1: right = 16'h7FFF;
        2: begin
          left = 16'h7FFF;
          right = 16'h8000;
        end
        3: begin
          left = '0;
          right = '0;
        end
        default: begin
          left = 16'($signed(left) >>> shift);
          right = 16'($signed(right) >>> shift);
        end
      endcase
      send_frame({right, left});
    end
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (meter_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DAT_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    meter_sb.write_reg(idx, value);
  endtask

  // upper bits of the narrow registers carry junk, which must be dropped
  task automatic apply_setting(logic [31:0] b0, logic [31:0] b1, logic [31:0] a1,
                               logic [31:0] a2, logic [15:0] ld, logic [15:0] pd,
                               logic [1:0] ch);
    cfg_write(CFG_B0, b0);
    cfg_write(CFG_B1, b1);
    cfg_write(CFG_A1, a1);
    cfg_write(CFG_A2, a2);
    cfg_write(CFG_LOCAL_DECAY, {16'($urandom), ld});
    cfg_write(CFG_PEAK_DECAY, {16'($urandom), pd});
    cfg_write(CFG_CHAN_COUNT, {30'($urandom), ch});
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    meter_sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    src_idling = 1'b1;
    sink_idling = 1'b1;
    hold_off_req = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients: extremes, then silence to watch the decay
    foreach (OPENING_FRAMES[i]) send_frame(OPENING_FRAMES[i]);
    hold_off_req = 1'b1;
    run_frames(200);
    drain_pipeline();

    apply_setting(32'h4000_0000, '0, '0, '0, 16'h0000, 16'h0000, CHAN_ONE);
    run_frames(150);
    drain_pipeline();

    apply_setting(32'h4000_0000, '0, '0, '0, 16'hFFFF, 16'hFFFF, 2'd3);
    run_frames(150);
    drain_pipeline();

    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'($urandom), 16'($urandom), 2'd0);
    run_frames(100);
    drain_pipeline();

    apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  16'($urandom), 16'($urandom), 2'd2);
    run_frames(80);
    drain_pipeline();

    repeat (3) begin
      apply_setting(32'($signed($urandom) >>> $urandom_range(0, 6)),
                    32'($signed($urandom) >>> $urandom_range(0, 6)),
                    32'($signed($urandom) >>> $urandom_range(2, 12)),
                    32'($signed($urandom) >>> $urandom_range(2, 12)),
                    16'($urandom), 16'($urandom), 2'($urandom_range(0, 3)));
      run_frames(100);
      drain_pipeline();
    end

    // back to defaults, no idling on either side
    src_idling = 1'b0;
    sink_idling = 1'b0;
    apply_setting(B0_RST, B1_RST, A1_RST, A2_RST, LOCAL_DECAY_RST, PEAK_DECAY_RST, CHAN_RST);
    run_frames(300);
    drain_pipeline();

    if (meter_sb.mismatches == 0 && meter_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: audio_level_meter_bargraph_core.f
rtl/core/alm_pkg.sv
rtl/core/alm_biquad.sv
rtl/core/alm_level.sv
rtl/core/alm_bargraph.sv
rtl/core/audio_level_meter_bargraph_core.sv
dv/tb_audio_level_meter_bargraph_core.sv
